FILE: rtl/mtxrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtxrb_pkg
// Shared types and constants for the message-admitting transmit ring buffer.
// ----------------------------------------------------------------------------
package mtxrb_pkg;

  localparam int DEPTH_DEF = 32768;

  localparam int OP_W  = 2;
  localparam int LEN_W = 16;
  localparam int BYTE_W = 8;
  localparam int CMP_W = 17;

  localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
  localparam logic [OP_W-1:0] OP_DATA  = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;

  typedef struct packed {
    logic capture;
    logic execute;
  } mtxrb_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/message_admitting_tx_ring_buffer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// message_admitting_tx_ring_buffer_top
// Byte ring buffer with all-or-nothing message admission feeding a UART.
// ----------------------------------------------------------------------------
// Each beat is handled in order: the beat is registered, then the single-port
// ring memory is written or read and the pointers and fill count move, and
// then the result is shown on the output channel until it is taken. The next
// beat is taken once the result has been taken. A begin beat admits its
// message only if free space covers the whole length; data beats are stored
// while the admitted count lasts, and a drain beat sends the oldest byte when
// the transmitter FIFO is not full. No clearing pass is needed after reset.
module message_admitting_tx_ring_buffer_top
  import mtxrb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   op,
  input  wire logic [LEN_W-1:0]  msg_length,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              fifo_full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   admitted,
  output logic                   tx_valid,
  output logic [BYTE_W-1:0]      tx_byte,
  output logic [LEN_W-1:0]       fill_level,
  output logic [LEN_W-1:0]       free_space
);

  mtxrb_cmd_t cmd;

  mtxrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  mtxrb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (op),
    .msg_length (msg_length),
    .data_byte  (data_byte),
    .fifo_full  (fifo_full),
    .admitted   (admitted),
    .tx_valid   (tx_valid),
    .tx_byte    (tx_byte),
    .fill_level (fill_level),
    .free_space (free_space)
  );

endmodule
`default_nettype wire

FILE: rtl/mtxrb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtxrb_ctrl
// Sequencer: takes one beat, runs it through the datapath, holds the result.
// ----------------------------------------------------------------------------
module mtxrb_ctrl
  import mtxrb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output mtxrb_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall    = (state != S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.execute = (state == S_EXEC);

`ifndef SYNTH
  a_exec_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> out_valid)
    else $error("execute not followed by result");
  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> cmd.execute)
    else $error("accepted beat not executed");
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("beat accepted while result pending");
`endif

endmodule
`default_nettype wire

FILE: rtl/mtxrb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtxrb_dp
// Ring memory, pointers, fill count and admission bookkeeping.
// ----------------------------------------------------------------------------
module mtxrb_dp
  import mtxrb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mtxrb_cmd_t        cmd,
  input  wire logic [OP_W-1:0]   op,
  input  wire logic [LEN_W-1:0]  msg_length,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              fifo_full,
  output logic                   admitted,
  output logic                   tx_valid,
  output logic [BYTE_W-1:0]      tx_byte,
  output logic [LEN_W-1:0]       fill_level,
  output logic [LEN_W-1:0]       free_space
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  logic [BYTE_W-1:0] mem [DEPTH];

  logic [OP_W-1:0]   op_q;
  logic [LEN_W-1:0]  len_q;
  logic [BYTE_W-1:0] byte_q;
  logic              full_q;

  logic [PW-1:0]     rd_ptr;
  logic [PW-1:0]     wr_ptr;
  logic [LW-1:0]     level;
  logic [LEN_W-1:0]  bytes_to_accept;
  logic [BYTE_W-1:0] rd_data;
  logic              adm_q;
  logic              txv_q;

  logic [LW-1:0] free_now;
  logic          begin_ok;
  logic          wr_en;
  logic          rd_en;
  logic [PW-1:0] rd_ptr_inc;
  logic [PW-1:0] wr_ptr_inc;

  assign free_now   = LW'(DEPTH) - level;
  assign begin_ok   = CMP_W'(free_now) >= CMP_W'(len_q);
  assign wr_en      = cmd.execute && (op_q == OP_DATA) && (bytes_to_accept != '0)
                      && (level != LW'(DEPTH));
  assign rd_en      = cmd.execute && (op_q == OP_DRAIN) && !full_q && (level != '0);
  assign rd_ptr_inc = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
  assign wr_ptr_inc = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      len_q  <= msg_length;
      byte_q <= data_byte;
      full_q <= fifo_full;
    end
  end

  // ring memory, synchronous read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= byte_q;
    if (rd_en) rd_data <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr          <= '0;
      wr_ptr          <= '0;
      level           <= '0;
      bytes_to_accept <= '0;
      adm_q           <= 1'b0;
      txv_q           <= 1'b0;
    end else if (cmd.execute) begin
      adm_q <= 1'b0;
      txv_q <= rd_en;
      if (op_q == OP_BEGIN) begin
        adm_q           <= begin_ok;
        bytes_to_accept <= begin_ok ? len_q : '0;
      end
      if (wr_en) begin
        wr_ptr          <= wr_ptr_inc;
        level           <= level + LW'(1);
        bytes_to_accept <= bytes_to_accept - LEN_W'(1);
        adm_q           <= 1'b1;
      end
      if (rd_en) begin
        // last byte out: both pointers go home
        if (level == LW'(1)) begin
          rd_ptr <= '0;
          wr_ptr <= '0;
        end else begin
          rd_ptr <= rd_ptr_inc;
        end
        level <= level - LW'(1);
      end
    end
  end

  assign admitted   = adm_q;
  assign tx_valid   = txv_q;
  assign tx_byte    = txv_q ? rd_data : '0;
  assign fill_level = LEN_W'(level);
  assign free_space = LEN_W'(free_now);

endmodule
`default_nettype wire

FILE: verif/message_admitting_tx_ring_buffer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// message_admitting_tx_ring_buffer_top_tb
// Drives begin, data, drain and no-op beats into the transmit ring buffer and
// compares every result beat with its typed table row or with a behavioral copy
// of the ring kept here. A short table of hand-picked beats comes first. Random
// message traffic then runs under four idling patterns on the two channels.
// ----------------------------------------------------------------------------
module message_admitting_tx_ring_buffer_top_tb;
  import mtxrb_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int LIMIT_NS = 40_000_000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic              adm;
    logic              txv;
    logic [BYTE_W-1:0] txb;
    logic [LEN_W-1:0]  lvl;
    logic [LEN_W-1:0]  spare;
  } beat_result_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] dat;
    logic              full;
    bit                typed;
    beat_result_t      r;
  } table_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   op;
  logic [LEN_W-1:0]  msg_length;
  logic [BYTE_W-1:0] data_byte;
  logic              fifo_full;
  logic              out_valid;
  logic              out_stall;
  logic              admitted;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic [LEN_W-1:0]  fill_level;
  logic [LEN_W-1:0]  free_space;

  message_admitting_tx_ring_buffer_top #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .msg_length (msg_length),
    .data_byte  (data_byte),
    .fifo_full  (fifo_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .admitted   (admitted),
    .tx_valid   (tx_valid),
    .tx_byte    (tx_byte),
    .fill_level (fill_level),
    .free_space (free_space)
  );

  // shadow copy of the ring
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  int unsigned       rd_idx;
  int unsigned       wr_idx;
  int unsigned       owed;
  bit                ring_empty;

  beat_result_t      pending_results[$];
  table_row_t        dir_rows[$];
  int                err_count;
  int                send_pct;
  int                stall_pct;

  function automatic int unsigned held_bytes();
    int unsigned d;
    if (ring_empty) return 0;
    d = (wr_idx + DEPTH - rd_idx) % DEPTH;
    return (d == 0) ? DEPTH : d;
  endfunction

  function automatic beat_result_t ring_step(logic [OP_W-1:0] b_op, logic [LEN_W-1:0] b_len,
                                             logic [BYTE_W-1:0] b_dat, logic b_full);
    beat_result_t r;
    int unsigned  lvl;
    r = '0;
    case (b_op)
      OP_BEGIN: begin
        if (DEPTH - held_bytes() >= b_len) begin
          r.adm = 1'b1;
          owed = b_len;
        end else begin
          owed = 0;
        end
      end
      OP_DATA: begin
        if (owed > 0 && held_bytes() < DEPTH) begin
          ring_mem[wr_idx] = b_dat;
          wr_idx = (wr_idx + 1) % DEPTH;
          ring_empty = 1'b0;
          owed--;
          r.adm = 1'b1;
        end
      end
      OP_DRAIN: begin
        if (!b_full && !ring_empty) begin
          r.txv = 1'b1;
          r.txb = ring_mem[rd_idx];
          rd_idx = (rd_idx + 1) % DEPTH;
          // ring ran dry: both pointers go home
          if (rd_idx == wr_idx) begin
            ring_empty = 1'b1;
            rd_idx = 0;
            wr_idx = 0;
          end
        end
      end
      default: ;
    endcase
    lvl = held_bytes();
    r.lvl = lvl[LEN_W-1:0];
    r.spare = LEN_W'(DEPTH - lvl);
    return r;
  endfunction

  function automatic table_row_t mk_row(logic [OP_W-1:0] r_op, logic [LEN_W-1:0] r_len,
                                        logic [BYTE_W-1:0] r_dat, logic r_full, bit typed,
                                        logic r_adm, logic r_txv, logic [BYTE_W-1:0] r_txb,
                                        logic [LEN_W-1:0] r_lvl, logic [LEN_W-1:0] r_spare);
    table_row_t row;
    row.op = r_op;
    row.len = r_len;
    row.dat = r_dat;
    row.full = r_full;
    row.typed = typed;
    row.r.adm = r_adm;
    row.r.txv = r_txv;
    row.r.txb = r_txb;
    row.r.lvl = r_lvl;
    row.r.spare = r_spare;
    return row;
  endfunction

  task automatic set_idle(idle_mode_t mode);
    send_pct = (mode == IDLE_SEND) ? 67 : (mode == IDLE_BOTH) ? 17 : 0;
    stall_pct = (mode == IDLE_RECV) ? 67 : (mode == IDLE_BOTH) ? 17 : 0;
  endtask

  // called just after a falling edge; returns just after a falling edge
  task automatic send_beat(logic [OP_W-1:0] b_op, logic [LEN_W-1:0] b_len,
                           logic [BYTE_W-1:0] b_dat, logic b_full,
                           bit typed, beat_result_t typed_r);
    beat_result_t model_r;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    op = b_op;
    msg_length = b_len;
    data_byte = b_dat;
    fifo_full = b_full;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    model_r = ring_step(b_op, b_len, b_dat, b_full);
    pending_results.push_back(typed ? typed_r : model_r);
    @(negedge clk);
  endtask

  task automatic random_traffic(int n_items);
    int sent;
    int pick;
    int len;
    int room;
    int n_data;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      room = DEPTH - held_bytes();
      if (pick < 65) begin
        // message: begin then data beats, at times more or fewer than its length, drains mixed in
        pick = $urandom_range(99);
        if (pick < 75) len = $urandom_range(24, 1);
        else if (pick < 85) len = $urandom_range(2, 0);
        else if (pick < 95) len = (room < DEPTH) ? room + $urandom_range(8, 1) : DEPTH;
        else len = DEPTH;
        if (len > DEPTH) len = DEPTH;
        send_beat(OP_BEGIN, len[LEN_W-1:0], BYTE_W'($urandom_range(255)),
                  1'($urandom_range(1)), 1'b0, '0);
        sent++;
        n_data = (len > 40) ? $urandom_range(40, 1) : len;
        pick = $urandom_range(99);
        if (pick < 15) n_data += $urandom_range(3, 1);
        else if (pick < 25) n_data = $urandom_range(n_data, 0);
        for (int j = 0; j < n_data; j++) begin
          send_beat(OP_DATA, LEN_W'($urandom_range(65535)), BYTE_W'($urandom_range(255)),
                    1'($urandom_range(1)), 1'b0, '0);
          sent++;
          if ($urandom_range(1) == 1) begin
            send_beat(OP_DRAIN, '0, '0, 1'($urandom_range(3) == 0), 1'b0, '0);
            sent++;
          end
        end
      end else if (pick < 85) begin
        n_data = $urandom_range(16, 1);
        for (int j = 0; j < n_data; j++) begin
          send_beat(OP_DRAIN, LEN_W'($urandom_range(65535)), BYTE_W'($urandom_range(255)),
                    1'($urandom_range(3) == 0), 1'b0, '0);
          sent++;
        end
      end else if (pick < 92) begin
        while (held_bytes() != 0) begin
          send_beat(OP_DRAIN, '0, '0, 1'b0, 1'b0, '0);
          sent++;
        end
      end else begin
        // stray beats: no-op, orphan byte, blocked drain
        pick = $urandom_range(2);
        if (pick == 0) begin
          send_beat(OP_NOP, LEN_W'($urandom_range(65535)), BYTE_W'($urandom_range(255)),
                    1'($urandom_range(1)), 1'b0, '0);
        end else if (pick == 1) begin
          send_beat(OP_DATA, '0, BYTE_W'($urandom_range(255)), 1'b0, 1'b0, '0);
        end else begin
          send_beat(OP_DRAIN, '0, '0, 1'b1, 1'b0, '0);
        end
        sent++;
      end
    end
  endtask

  task automatic check_field(string what, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    beat_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: result beat with nothing expected, expected none, got %0h",
                 $time, {admitted, tx_valid, tx_byte, fill_level, free_space});
      end else begin
        want = pending_results.pop_front();
        check_field("admitted", LEN_W'(want.adm), LEN_W'(admitted));
        check_field("tx_valid", LEN_W'(want.txv), LEN_W'(tx_valid));
        check_field("tx_byte", LEN_W'(want.txb), LEN_W'(tx_byte));
        check_field("fill_level", want.lvl, fill_level);
        check_field("free_space", want.spare, free_space);
      end
    end
  end

  initial begin
    #LIMIT_NS;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_NOP;
    msg_length = '0;
    data_byte = '0;
    fifo_full = 1'b0;
    err_count = 0;
    rd_idx = 0;
    wr_idx = 0;
    owed = 0;
    ring_empty = 1'b1;
    set_idle(IDLE_NONE);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // op, length, byte, fifo full, typed, admitted, tx valid, tx byte, level, free
    dir_rows.push_back(mk_row(OP_DRAIN, 0, 0, 0, 1, 0, 0, 0, 0, 16'h8000));
    dir_rows.push_back(mk_row(OP_NOP, 16'hFFFF, 8'hFF, 1, 1, 0, 0, 0, 0, 16'h8000));
    dir_rows.push_back(mk_row(OP_DATA, 0, 8'h3C, 0, 1, 0, 0, 0, 0, 16'h8000));
    dir_rows.push_back(mk_row(OP_BEGIN, 0, 0, 0, 1, 1, 0, 0, 0, 16'h8000));
    dir_rows.push_back(mk_row(OP_DATA, 0, 8'hC3, 0, 1, 0, 0, 0, 0, 16'h8000));
    dir_rows.push_back(mk_row(OP_BEGIN, 16'h8000, 0, 0, 1, 1, 0, 0, 0, 16'h8000));
    dir_rows.push_back(mk_row(OP_BEGIN, 3, 0, 0, 1, 1, 0, 0, 0, 16'h8000));
    dir_rows.push_back(mk_row(OP_DATA, 0, 8'h00, 0, 1, 1, 0, 0, 1, 16'h7FFF));
    dir_rows.push_back(mk_row(OP_DATA, 0, 8'hFF, 1, 1, 1, 0, 0, 2, 16'h7FFE));
    dir_rows.push_back(mk_row(OP_DATA, 0, 8'hA5, 0, 1, 1, 0, 0, 3, 16'h7FFD));
    dir_rows.push_back(mk_row(OP_DATA, 0, 8'h77, 0, 1, 0, 0, 0, 3, 16'h7FFD));
    dir_rows.push_back(mk_row(OP_DRAIN, 0, 0, 1, 1, 0, 0, 0, 3, 16'h7FFD));
    dir_rows.push_back(mk_row(OP_DRAIN, 0, 0, 0, 1, 0, 1, 8'h00, 2, 16'h7FFE));
    dir_rows.push_back(mk_row(OP_BEGIN, 16'h7FFF, 0, 0, 1, 0, 0, 0, 2, 16'h7FFE));
    dir_rows.push_back(mk_row(OP_DATA, 0, 8'h11, 0, 1, 0, 0, 0, 2, 16'h7FFE));
    dir_rows.push_back(mk_row(OP_BEGIN, 16'h7FFE, 0, 0, 1, 1, 0, 0, 2, 16'h7FFE));
    dir_rows.push_back(mk_row(OP_BEGIN, 1, 8'hFF, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_DATA, 16'hFFFF, 8'h5A, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_DATA, 0, 8'h66, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OP_DRAIN, 0, 0, 0, 1, 0, 1, 8'hFF, 2, 16'h7FFE));
    dir_rows.push_back(mk_row(OP_DRAIN, 0, 0, 1, 1, 0, 0, 0, 2, 16'h7FFE));
    dir_rows.push_back(mk_row(OP_DRAIN, 0, 0, 0, 1, 0, 1, 8'hA5, 1, 16'h7FFF));
    dir_rows.push_back(mk_row(OP_DRAIN, 0, 0, 0, 1, 0, 1, 8'h5A, 0, 16'h8000));
    dir_rows.push_back(mk_row(OP_DRAIN, 0, 0, 0, 1, 0, 0, 0, 0, 16'h8000));
    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].len, dir_rows[i].dat, dir_rows[i].full,
                dir_rows[i].typed, dir_rows[i].r);

    set_idle(IDLE_NONE);
    random_traffic(375);
    set_idle(IDLE_SEND);
    random_traffic(375);
    set_idle(IDLE_RECV);
    random_traffic(375);
    set_idle(IDLE_BOTH);
    random_traffic(375);

    in_valid = 1'b0;
    set_idle(IDLE_NONE);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
